// ===== design/stpq_pkg.sv =====
// Package for the sorted periodic timer queue.
// Holds payload structs, list entry layout, command and result codes and FSM states.
// No dependencies.
package stpq_pkg;

  localparam int DEF_QUEUE_DEPTH = 16;
  localparam int DEF_FIFO_DEPTH  = 2;
  localparam logic [30:0] IDENT_LIMIT = 31'd2000000000;

  typedef enum logic [1:0] {
    CMD_REGISTER = 2'd0,
    CMD_REMOVE   = 2'd1,
    CMD_TICK     = 2'd2
  } cmd_e;

  typedef enum logic [2:0] {
    KIND_REGISTERED = 3'd0,
    KIND_REJECTED   = 3'd1,
    KIND_FIRED      = 3'd2,
    KIND_REMOVED    = 3'd3,
    KIND_NOT_FOUND  = 3'd4,
    KIND_TICK_DONE  = 3'd5
  } kind_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_INS_RD,
    S_INS_CMP,
    S_RM_RD,
    S_RM_CMP,
    S_SH_RD,
    S_SH_WR,
    S_TK_RD,
    S_TK_CMP,
    S_REINS,
    S_RE_LD,
    S_OUT
  } state_e;

  typedef struct packed {
    logic [1:0]  command;
    logic [31:0] expire_time;
    logic [15:0] repeat_count;
    logic [23:0] period_seconds;
    logic [15:0] handler_tag;
    logic [30:0] target_id;
    logic [31:0] now_time;
  } in_t;

  typedef struct packed {
    logic [2:0]  result_kind;
    logic [30:0] timer_ident_out;
    logic [15:0] tag_out;
    logic        closed_flag;
    logic [31:0] next_wait;
    logic        last_flag;
  } out_t;

  typedef struct packed {
    logic [31:0] expiry;
    logic [15:0] left;
    logic [23:0] period;
    logic [30:0] ident;
    logic [15:0] tag;
  } entry_t;

endpackage

// ===== design/stpq_fifo.sv =====
// Small register FIFO that decouples the command side and the result side.
// Depends on nothing but its type parameter.
module stpq_fifo #(
  parameter type T = logic,
  parameter int DEPTH = 2
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  T     data_i,
  output logic full_o,
  input  logic pop_i,
  output T     data_o,
  output logic empty_o
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  T              mem_q [DEPTH];
  logic [AW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          do_push, do_pop;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + AW'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + AW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

// ===== design/stpq_engine.sv =====
// Back end of the timer queue: sorted list in a circular memory, walked one entry at a time.
// Depends on stpq_pkg.
module stpq_engine import stpq_pkg::*; #(
  parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cmd_valid_i,
  input  in_t  cmd_i,
  output logic cmd_pop_o,
  input  logic res_full_i,
  output logic res_push_o,
  output out_t res_o
);

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  entry_t list_mem [QUEUE_DEPTH];
  entry_t surv_mem [QUEUE_DEPTH];
  entry_t rdata_q, surv_rdata_q;

  state_e        state_q, state_d, ret_q, ret_d;
  in_t           cmd_q, cmd_d;
  entry_t        ins_q, ins_d;
  out_t          res_q, res_d;
  logic [CW-1:0] idx_q, idx_d, total_q, total_d, ns_q, ns_d, j_q, j_d;
  logic [AW-1:0] head_q, head_d;
  logic [31:0]   wait_q, wait_d;
  logic [30:0]   id_q, id_d, nid;

  logic          mem_re, mem_we, surv_we;
  logic [AW-1:0] mem_raddr, mem_waddr;
  entry_t        mem_wdata, surv_wdata;
  logic [32:0]   sum_exp;

  // Offset from the head, wrapped around the circular list.
  function automatic logic [AW-1:0] phys(input logic [AW-1:0] head,
                                         input logic [CW-1:0] off);
    logic [CW:0] s;
    s = (CW+1)'(head) + (CW+1)'(off);
    if (s >= (CW+1)'(QUEUE_DEPTH)) begin
      s = s - (CW+1)'(QUEUE_DEPTH);
    end
    return s[AW-1:0];
  endfunction

  assign res_o      = res_q;
  assign res_push_o = (state_q == S_OUT) && !res_full_i;
  assign nid        = (id_q == IDENT_LIMIT - 31'd1) ? '0 : id_q + 31'd1;
  assign sum_exp    = {1'b0, rdata_q.expiry} + 33'(rdata_q.period);

  always_comb begin
    state_d    = state_q;
    ret_d      = ret_q;
    cmd_d      = cmd_q;
    ins_d      = ins_q;
    res_d      = res_q;
    idx_d      = idx_q;
    total_d    = total_q;
    ns_d       = ns_q;
    j_d        = j_q;
    head_d     = head_q;
    wait_d     = wait_q;
    id_d       = id_q;
    cmd_pop_o  = 1'b0;
    mem_re     = 1'b0;
    mem_raddr  = '0;
    mem_we     = 1'b0;
    mem_waddr  = '0;
    mem_wdata  = ins_q;
    surv_we    = 1'b0;
    surv_wdata = rdata_q;

    case (state_q)
      S_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          cmd_d     = cmd_i;
          ret_d     = S_IDLE;
          case (cmd_i.command)
            CMD_REGISTER: begin
              id_d = nid;
              if (total_q >= CW'(QUEUE_DEPTH)) begin
                res_d   = '{result_kind: KIND_REJECTED, timer_ident_out: nid,
                            tag_out: cmd_i.handler_tag, closed_flag: 1'b0,
                            next_wait: '0, last_flag: 1'b1};
                state_d = S_OUT;
              end else begin
                ins_d   = '{expiry: cmd_i.expire_time, left: cmd_i.repeat_count,
                            period: cmd_i.period_seconds, ident: nid,
                            tag: cmd_i.handler_tag};
                idx_d   = total_q;
                state_d = S_INS_RD;
              end
            end
            CMD_REMOVE: begin
              idx_d   = '0;
              state_d = S_RM_RD;
            end
            CMD_TICK: begin
              ns_d    = '0;
              j_d     = '0;
              wait_d  = 32'd1;
              state_d = S_TK_RD;
            end
            default: state_d = S_IDLE;
          endcase
        end
      end

      // Insertion walks from the tail, moving later-or-equal entries up by one.
      S_INS_RD, S_INS_CMP: begin
        if (state_q == S_INS_RD && idx_q != '0) begin
          mem_re    = 1'b1;
          mem_raddr = phys(head_q, idx_q - CW'(1));
          state_d   = S_INS_CMP;
        end else if (state_q == S_INS_CMP && rdata_q.expiry >= ins_q.expiry) begin
          mem_we    = 1'b1;
          mem_waddr = phys(head_q, idx_q);
          mem_wdata = rdata_q;
          idx_d     = idx_q - CW'(1);
          state_d   = S_INS_RD;
        end else begin
          mem_we    = 1'b1;
          mem_waddr = phys(head_q, idx_q);
          mem_wdata = ins_q;
          total_d   = total_q + CW'(1);
          if (cmd_q.command == CMD_TICK) begin
            state_d = S_REINS;
          end else begin
            res_d   = '{result_kind: KIND_REGISTERED, timer_ident_out: ins_q.ident,
                        tag_out: ins_q.tag, closed_flag: 1'b0, next_wait: '0,
                        last_flag: 1'b1};
            ret_d   = S_IDLE;
            state_d = S_OUT;
          end
        end
      end

      S_RM_RD: begin
        if (idx_q >= total_q) begin
          res_d   = '{result_kind: KIND_NOT_FOUND, timer_ident_out: cmd_q.target_id,
                      tag_out: '0, closed_flag: 1'b0, next_wait: '0, last_flag: 1'b1};
          state_d = S_OUT;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = phys(head_q, idx_q);
          state_d   = S_RM_CMP;
        end
      end

      S_RM_CMP: begin
        if (rdata_q.ident == cmd_q.target_id) begin
          res_d   = '{result_kind: KIND_REMOVED, timer_ident_out: cmd_q.target_id,
                      tag_out: rdata_q.tag, closed_flag: 1'b0, next_wait: '0,
                      last_flag: 1'b1};
          state_d = S_SH_RD;
        end else begin
          idx_d   = idx_q + CW'(1);
          state_d = S_RM_RD;
        end
      end

      // Close the gap left by a removed entry.
      S_SH_RD: begin
        if ((CW+1)'(idx_q) + (CW+1)'(1) >= (CW+1)'(total_q)) begin
          total_d = total_q - CW'(1);
          state_d = S_OUT;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = phys(head_q, idx_q + CW'(1));
          state_d   = S_SH_WR;
        end
      end

      S_SH_WR: begin
        mem_we    = 1'b1;
        mem_waddr = phys(head_q, idx_q);
        mem_wdata = rdata_q;
        idx_d     = idx_q + CW'(1);
        state_d   = S_SH_RD;
      end

      S_TK_RD: begin
        if (total_q == '0) begin
          state_d = S_REINS;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = head_q;
          state_d   = S_TK_CMP;
        end
      end

      S_TK_CMP: begin
        if (rdata_q.expiry > cmd_q.now_time) begin
          wait_d  = rdata_q.expiry - cmd_q.now_time;
          state_d = S_REINS;
        end else begin
          res_d = '{result_kind: KIND_FIRED, timer_ident_out: rdata_q.ident,
                    tag_out: rdata_q.tag, closed_flag: (rdata_q.left <= 16'd1),
                    next_wait: '0, last_flag: 1'b0};
          if (rdata_q.left > 16'd1) begin
            surv_we           = 1'b1;
            surv_wdata.expiry = sum_exp[32] ? 32'hFFFF_FFFF : sum_exp[31:0];
            surv_wdata.left   = rdata_q.left - 16'd1;
            ns_d              = ns_q + CW'(1);
          end
          head_d  = phys(head_q, CW'(1));
          total_d = total_q - CW'(1);
          ret_d   = S_TK_RD;
          state_d = S_OUT;
        end
      end

      S_REINS: begin
        if (j_q == ns_q) begin
          res_d   = '{result_kind: KIND_TICK_DONE, timer_ident_out: '0, tag_out: '0,
                      closed_flag: 1'b0, next_wait: wait_q, last_flag: 1'b1};
          ret_d   = S_IDLE;
          state_d = S_OUT;
        end else begin
          state_d = S_RE_LD;
        end
      end

      S_RE_LD: begin
        ins_d   = surv_rdata_q;
        idx_d   = total_q;
        j_d     = j_q + CW'(1);
        state_d = S_INS_RD;
      end

      S_OUT: begin
        if (!res_full_i) begin
          state_d = ret_q;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ret_q   <= S_IDLE;
      idx_q   <= '0;
      total_q <= '0;
      ns_q    <= '0;
      j_q     <= '0;
      head_q  <= '0;
      id_q    <= '0;
    end else begin
      state_q <= state_d;
      ret_q   <= ret_d;
      idx_q   <= idx_d;
      total_q <= total_d;
      ns_q    <= ns_d;
      j_q     <= j_d;
      head_q  <= head_d;
      id_q    <= id_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q  <= cmd_d;
    ins_q  <= ins_d;
    res_q  <= res_d;
    wait_q <= wait_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      list_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= list_mem[mem_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (surv_we) begin
      surv_mem[ns_q[AW-1:0]] <= surv_wdata;
    end
    if (j_q < ns_q) begin
      surv_rdata_q <= surv_mem[j_q[AW-1:0]];
    end
  end

endmodule

// ===== design/sorted_periodic_timer_queue.sv =====
// Sorted periodic timer queue. Register and remove walk the sorted list; a tick fires the
// due timers from the head and re-queues those with repeats left by sorted insertion.
// One command is worked on at a time; commands and results pass two-entry FIFOs. Reset
// clears the timer count, the list head and the id counter; list memory is not reset.
module sorted_periodic_timer_queue import stpq_pkg::*; #(
  parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push,
  output logic full,
  input  in_t  in_i,
  output logic empty,
  input  logic pop,
  output out_t out_o
);

  logic cmd_empty, cmd_pop, res_full, res_push;
  in_t  cmd_head;
  out_t res_data;

  stpq_fifo #(.T(in_t), .DEPTH(DEF_FIFO_DEPTH)) u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (in_i),
    .full_o  (full),
    .pop_i   (cmd_pop),
    .data_o  (cmd_head),
    .empty_o (cmd_empty)
  );

  stpq_engine #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (!cmd_empty),
    .cmd_i       (cmd_head),
    .cmd_pop_o   (cmd_pop),
    .res_full_i  (res_full),
    .res_push_o  (res_push),
    .res_o       (res_data)
  );

  stpq_fifo #(.T(out_t), .DEPTH(DEF_FIFO_DEPTH)) u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res_data),
    .full_o  (res_full),
    .pop_i   (pop),
    .data_o  (out_o),
    .empty_o (empty)
  );

endmodule

// ===== tb/stpq_checker.sv =====
// Checker for the sorted periodic timer queue: watches both queue-style channels,
// keeps its own copy of the timer list, predicts every result and compares it.
// Depends on stpq_pkg.
module stpq_checker import stpq_pkg::*; #(
  parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  logic full_i,
  input  in_t  in_i,
  input  logic empty_i,
  input  logic pop_i,
  input  out_t out_i,
  output int   fail_count_o,
  output int   pending_o,
  output int   fired_seen_o,
  output int   rejected_seen_o
);
  timeunit 1ns;
  timeprecision 1ps;

  entry_t timer_list[$];
  logic [30:0] last_ident;
  out_t expected_results[$];

  assign pending_o = expected_results.size();

  function automatic void add_sorted(entry_t e);
    int pos;
    pos = 0;
    while (pos < timer_list.size() && timer_list[pos].expiry < e.expiry) pos++;
    timer_list.insert(pos, e);
  endfunction

  function automatic void queue_result(out_t r);
    expected_results.insert(expected_results.size(), r);
  endfunction

  function automatic out_t make_result(kind_e k, logic [30:0] id, logic [15:0] tag,
                                       logic closed, logic [31:0] wait_s, logic last);
    out_t r;
    r.result_kind = k;
    r.timer_ident_out = id;
    r.tag_out = tag;
    r.closed_flag = closed;
    r.next_wait = wait_s;
    r.last_flag = last;
    return r;
  endfunction

  // Applies one accepted command to the timer list and queues what it yields.
  function automatic void predict_command(in_t c);
    entry_t e;
    entry_t survivors[$];
    logic [32:0] later;
    logic [31:0] wait_s;
    bit found;
    case (c.command)
      CMD_REGISTER: begin
        last_ident = (last_ident == IDENT_LIMIT - 1) ? 31'd0 : last_ident + 31'd1;
        if (timer_list.size() >= QUEUE_DEPTH) begin
          queue_result(make_result(KIND_REJECTED, last_ident,
                                   c.handler_tag, 1'b0, 32'd0, 1'b1));
        end else begin
          e.expiry = c.expire_time;
          e.left = c.repeat_count;
          e.period = c.period_seconds;
          e.ident = last_ident;
          e.tag = c.handler_tag;
          add_sorted(e);
          queue_result(make_result(KIND_REGISTERED, last_ident,
                                   c.handler_tag, 1'b0, 32'd0, 1'b1));
        end
      end
      CMD_REMOVE: begin
        found = 0;
        for (int i = 0; i < timer_list.size(); i++) begin
          if (timer_list[i].ident == c.target_id) begin
            queue_result(make_result(KIND_REMOVED, c.target_id,
                                     timer_list[i].tag, 1'b0, 32'd0, 1'b1));
            timer_list.delete(i);
            found = 1;
            break;
          end
        end
        if (!found) begin
          queue_result(make_result(KIND_NOT_FOUND, c.target_id, 16'd0,
                                   1'b0, 32'd0, 1'b1));
        end
      end
      CMD_TICK: begin
        wait_s = 32'd1;
        while (timer_list.size() > 0) begin
          e = timer_list[0];
          if (e.expiry > c.now_time) begin
            wait_s = e.expiry - c.now_time;
            break;
          end
          queue_result(make_result(KIND_FIRED, e.ident, e.tag,
                                   e.left <= 16'd1, 32'd0, 1'b0));
          if (e.left > 16'd1) begin
            later = {1'b0, e.expiry} + {9'd0, e.period};
            e.expiry = later[32] ? 32'hFFFF_FFFF : later[31:0];
            e.left = e.left - 16'd1;
            survivors.insert(survivors.size(), e);
          end
          timer_list.delete(0);
        end
        foreach (survivors[i]) add_sorted(survivors[i]);
        queue_result(make_result(KIND_TICK_DONE, 31'd0, 16'd0, 1'b0,
                                 wait_s, 1'b1));
      end
      default: ;
    endcase
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    out_t want;
    if (!rst_ni) begin
      timer_list.delete();
      expected_results.delete();
      last_ident = '0;
      fail_count_o <= 0;
      fired_seen_o <= 0;
      rejected_seen_o <= 0;
    end else begin
      if (!empty_i && pop_i) begin
        if (expected_results.size() == 0) begin
          if (fail_count_o < 10) $display("ERROR: unexpected result %p", out_i);
          fail_count_o <= fail_count_o + 1;
        end else begin
          want = expected_results[0];
          expected_results.delete(0);
          if (out_i !== want) begin
            if (fail_count_o < 10) begin
              $display("ERROR: result mismatch expected %p actual %p", want, out_i);
            end
            fail_count_o <= fail_count_o + 1;
          end
          if (out_i.result_kind == KIND_FIRED) fired_seen_o <= fired_seen_o + 1;
          if (out_i.result_kind == KIND_REJECTED) rejected_seen_o <= rejected_seen_o + 1;
        end
      end
      // Results are checked before the new command is predicted; a result can
      // never come out in the same cycle as its own command transfer.
      if (push_i && !full_i) predict_command(in_i);
    end
  end
endmodule

// ===== tb/tb_top.sv =====
// Top of the timer queue testbench: clock, reset, command stimulus and verdict.
// Depends on stpq_pkg, sorted_periodic_timer_queue and stpq_checker.
module tb_top;
  import stpq_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_CYCLES = 3000000;
  localparam int HOLD_CYCLES = 300;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic push = 1'b0;
  logic pop = 1'b0;
  logic full, empty;
  in_t  cmd_item = '0;
  out_t result;
  int   fail_count, pending, fired_seen, rejected_seen;
  int   cycle_count = 0;
  int   sent = 0;
  bit   hold_results = 0;
  bit   start_hold = 0;
  logic [30:0] issued_ids = '0;

  sorted_periodic_timer_queue dut (
    .clk_i(clk), .rst_ni(rst_n), .push(push), .full(full), .in_i(cmd_item),
    .empty(empty), .pop(pop), .out_o(result)
  );

  stpq_checker checker_i (
    .clk_i(clk), .rst_ni(rst_n), .push_i(push), .full_i(full), .in_i(cmd_item),
    .empty_i(empty), .pop_i(pop), .out_i(result), .fail_count_o(fail_count),
    .pending_o(pending), .fired_seen_o(fired_seen), .rejected_seen_o(rejected_seen)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > MAX_CYCLES) begin
      $display("tb_top failed");
      $finish;
    end
  end

  function automatic int gap_length();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 3);
  endfunction

  // Long receiver hold, counted here so the sender can keep offering items.
  initial begin
    @(posedge rst_n);
    wait (start_hold);
    hold_results = 1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_results = 0;
  end

  // Result side: random pops, plus one long hold so the block backs up.
  initial begin
    int gap;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (hold_results) begin
        pop <= 1'b0;
      end else if ($urandom_range(0, 3) == 0) begin
        gap = gap_length();
        pop <= 1'b0;
        repeat (gap) @(posedge clk);
        pop <= 1'b1;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // Waits for the transfer of one command, then maybe idles.
  task automatic send_command(in_t c, bit allow_gap);
    cmd_item <= c;
    push <= 1'b1;
    @(posedge clk);
    while (full) @(posedge clk);
    if (c.command == CMD_REGISTER) issued_ids = issued_ids + 31'd1;
    sent++;
    if (allow_gap && $urandom_range(0, 2) == 0) begin
      push <= 1'b0;
      repeat (gap_length()) @(posedge clk);
    end
  endtask

  function automatic in_t random_fields();
    in_t c;
    c.command = CMD_REGISTER;
    c.expire_time = $urandom();
    c.repeat_count = 16'($urandom());
    c.period_seconds = 24'($urandom());
    c.handler_tag = 16'($urandom());
    c.target_id = 31'($urandom_range(0, 1999999999));
    c.now_time = $urandom();
    return c;
  endfunction

  function automatic in_t make_register(logic [31:0] exp_s, logic [15:0] cnt,
                                        logic [23:0] per);
    in_t c;
    c = random_fields();
    c.command = CMD_REGISTER;
    c.expire_time = exp_s;
    c.repeat_count = cnt;
    c.period_seconds = per;
    return c;
  endfunction

  function automatic in_t make_tick(logic [31:0] now_s);
    in_t c;
    c = random_fields();
    c.command = CMD_TICK;
    c.now_time = now_s;
    return c;
  endfunction

  function automatic in_t make_remove(logic [30:0] id);
    in_t c;
    c = random_fields();
    c.command = CMD_REMOVE;
    c.target_id = id;
    return c;
  endfunction

  initial begin
    in_t c;
    logic [31:0] clock_s;
    int r;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: extremes, zero repeat count, saturating period, equal expiries.
    send_command(make_tick(32'd0), 1);
    send_command(make_register(32'd0, 16'd0, 24'd0), 1);
    send_command(make_register(32'hFFFF_FFF0, 16'hFFFF, 24'hFF_FFFF), 1);
    send_command(make_register(32'd5, 16'd3, 24'd10), 1);
    send_command(make_register(32'd5, 16'd2, 24'd1), 1);
    send_command(make_remove(31'd3), 1);
    send_command(make_remove(31'd3), 1);
    send_command(make_remove(31'd1999999999), 1);
    send_command(make_tick(32'd7), 1);
    send_command(make_tick(32'hFFFF_FFFF), 1);
    send_command(make_tick(32'hFFFF_FFFF), 1);
    c = random_fields();
    c.command = cmd_e'(2'd3);
    send_command(c, 1);
    // Overfill the list so registrations get rejected, with the receiver held off.
    start_hold = 1;
    for (int i = 0; i < 18; i++) send_command(make_register(32'd100 + i[31:0], 16'd1, 24'd0), 0);
    send_command(make_tick(32'd200), 1);

    clock_s = 32'd1000;
    for (int i = 0; i < 350; i++) begin
      r = $urandom_range(0, 99);
      if (r < 45) begin
        c = make_register(clock_s + $urandom_range(0, 40), 16'($urandom_range(0, 4)),
                          24'($urandom_range(0, 20)));
        if ($urandom_range(0, 9) == 0) c = random_fields();
        if ($urandom_range(0, 19) == 0) c.period_seconds = 24'hFF_FFFF;
        send_command(c, 1);
      end else if (r < 60) begin
        if ($urandom_range(0, 2) == 0) c = make_remove(31'($urandom_range(0, 1999999999)));
        else c = make_remove(issued_ids - 31'($urandom_range(0, 10)));
        send_command(c, 1);
      end else if (r < 97) begin
        clock_s = clock_s + $urandom_range(0, 15);
        send_command(make_tick(clock_s), 1);
      end else begin
        c = random_fields();
        c.command = cmd_e'(2'd3);
        send_command(c, 1);
      end
    end
    push <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    $display("Sent %0d commands; saw %0d firings and %0d rejected registrations.",
             sent, fired_seen, rejected_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end
endmodule

// ===== files.f =====
design/stpq_pkg.sv
design/stpq_fifo.sv
design/stpq_engine.sv
design/sorted_periodic_timer_queue.sv
tb/stpq_checker.sv
tb/tb_top.sv
